### src/sfpf_pkg.sv
// ---------------------------------------------------------------------------
// sfpf_pkg: shared types and constants of the serial frame parser
// Holds the status codes, the register indexes, the per-frame state record
// and the result record passed between the parser logic and the top level.
// ---------------------------------------------------------------------------
package sfpf_pkg;

  // default frame geometry
  localparam int unsigned HEADER_LEN_DEF  = 4;
  localparam int unsigned TRAILER_LEN_DEF = 4;
  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAILER = 1'b1;

  // fletcher modulus
  localparam logic [7:0] FLETCHER_MOD = 8'hff;

  // frame status codes
  typedef enum logic [1:0] {
    ST_UNFINISHED = 2'd0,
    ST_RESET      = 2'd1,
    ST_VERIFIED   = 2'd2,
    ST_CKERR      = 2'd3
  } status_t;

  // state kept for the frame in progress
  typedef struct packed {
    logic [7:0]  command;
    logic [15:0] length;
    logic [15:0] checksum;
    logic [7:0]  sum_low;
    logic [7:0]  sum_high;
  } frame_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic        frame_end;
    logic [7:0]  command;
    logic [10:0] payload_length;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        payload_valid;
  } result_t;

endpackage

### src/sfpf_ifaces.sv
// ---------------------------------------------------------------------------
// sfpf channel interfaces
// Valid/ready channels for received bytes and for parser result words.
// ---------------------------------------------------------------------------

// received byte channel
interface sfpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface sfpf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        frame_end;
  logic [7:0]  command;
  logic [10:0] payload_length;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic        payload_valid;

  modport source (
    output valid, output status, output frame_end, output command,
    output payload_length, output payload_byte, output payload_index,
    output payload_valid, input ready
  );
  modport sink (
    input valid, input status, input frame_end, input command,
    input payload_length, input payload_byte, input payload_index,
    input payload_valid, output ready
  );
endinterface

### src/serial_frame_parser_fletcher_top.sv
// ---------------------------------------------------------------------------
// serial_frame_parser_fletcher_top: byte-wise frame parser with Fletcher-16
// Accepts one received byte per cycle while the result channel is not stalled
// and returns one result word per byte via the input and result registers;
// the rate is set by the combinational position decode and running-sum update
// between them. The frame is a header, a command byte, a big-endian length, a
// big-endian checksum, the payload and a trailer. The user must write header
// and trailer patterns on the configuration port while the parser is idle;
// the block does not check it. Payload bytes are passed straight through with
// their index, and the last trailer byte reports verified or checksum error.
// ---------------------------------------------------------------------------
module serial_frame_parser_fletcher_top #(
  parameter int unsigned HEADER_LEN  = sfpf_pkg::HEADER_LEN_DEF,
  parameter int unsigned TRAILER_LEN = sfpf_pkg::TRAILER_LEN_DEF,
  parameter int unsigned MAX_PAYLOAD = sfpf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  sfpf_byte_if.sink                           rx,
  sfpf_result_if.source                       result
);

  // position counter wide enough for a full frame, capped at 16 bits wide
  localparam int unsigned FRAME_MAX = HEADER_LEN + 5 + MAX_PAYLOAD + TRAILER_LEN;
  localparam int unsigned POS_RAW_W = $clog2(FRAME_MAX);
  localparam int unsigned POS_W     = (POS_RAW_W > 16) ? 16 : POS_RAW_W;

  logic [31:0]        header_pattern;
  logic [31:0]        trailer_pattern;
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               out_valid;
  sfpf_pkg::result_t  out_res;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;
  sfpf_pkg::frame_t   frame;
  sfpf_pkg::frame_t   frame_next;
  sfpf_pkg::result_t  res_next;
  logic               advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern  <= '0;
      trailer_pattern <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sfpf_pkg::REG_HEADER) begin
        header_pattern <= cfg_wdata;
      end
      if (cfg_index == sfpf_pkg::REG_TRAILER) begin
        trailer_pattern <= cfg_wdata;
      end
    end
  end

  // pipeline flow control
  assign advance  = s1_valid && (!out_valid || result.ready);
  assign rx.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // parser logic
  sfpf_parse #(
    .HEADER_LEN  (HEADER_LEN),
    .TRAILER_LEN (TRAILER_LEN),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .POS_W       (POS_W)
  ) u_parse (
    .pos             (pos),
    .cur             (frame),
    .rx_byte         (s1_byte),
    .header_pattern  (header_pattern),
    .trailer_pattern (trailer_pattern),
    .pos_next        (pos_next),
    .frame_next      (frame_next),
    .res             (res_next)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      frame <= '0;
    end else if (advance) begin
      pos   <= pos_next;
      frame <= frame_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // result channel
  assign result.valid          = out_valid;
  assign result.status         = out_res.status;
  assign result.frame_end      = out_res.frame_end;
  assign result.command        = out_res.command;
  assign result.payload_length = out_res.payload_length;
  assign result.payload_byte   = out_res.payload_byte;
  assign result.payload_index  = out_res.payload_index;
  assign result.payload_valid  = out_res.payload_valid;

`ifndef ASSERT_OFF
  // a completed frame is always reported as verified or checksum error
  a_frame_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.frame_end |->
      (out_res.status == sfpf_pkg::ST_VERIFIED) ||
      (out_res.status == sfpf_pkg::ST_CKERR))
    else $error("frame end without final status");

  // a payload word never carries a reset or frame end
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.payload_valid |->
      (out_res.status == sfpf_pkg::ST_UNFINISHED) && !out_res.frame_end)
    else $error("payload word with non-idle status");

  // a restart or frame end sends the parser back to the first header byte
  a_restart_pos: assert property (@(posedge clk) disable iff (rst)
    advance && ((res_next.status == sfpf_pkg::ST_RESET) || res_next.frame_end) |=>
      (pos == '0) && (frame == '0))
    else $error("parser did not restart");

  // the input side only stalls when both registers are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> s1_valid && out_valid && !result.ready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

### src/sfpf_parse.sv
// ---------------------------------------------------------------------------
// sfpf_parse: next-state and result logic of the frame parser
// Purely combinational: from the current byte position, frame state and the
// incoming byte it forms the result word and the state after that byte.
// ---------------------------------------------------------------------------
module sfpf_parse #(
  parameter int unsigned HEADER_LEN  = sfpf_pkg::HEADER_LEN_DEF,
  parameter int unsigned TRAILER_LEN = sfpf_pkg::TRAILER_LEN_DEF,
  parameter int unsigned MAX_PAYLOAD = sfpf_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned POS_W       = 11
) (
  input  logic [POS_W-1:0]    pos,
  input  sfpf_pkg::frame_t    cur,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         header_pattern,
  input  logic [31:0]         trailer_pattern,
  output logic [POS_W-1:0]    pos_next,
  output sfpf_pkg::frame_t    frame_next,
  output sfpf_pkg::result_t   res
);

  localparam int unsigned PAYLOAD_START = HEADER_LEN + 5;
  localparam int unsigned EXT_W = 17;

  // add modulo 255, both operands below 256 and the first below 255
  function automatic logic [7:0] add_mod(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, sfpf_pkg::FLETCHER_MOD}) begin
      s = s - {1'b0, sfpf_pkg::FLETCHER_MOD};
    end
    return s[7:0];
  endfunction

  logic [EXT_W-1:0] ext_pos;
  logic [EXT_W-1:0] pay_end;
  logic [EXT_W-1:0] trl_idx;
  logic [EXT_W-1:0] pay_idx;
  logic [15:0]      new_len;
  logic [7:0]       lo_next;
  logic [7:0]       hi_next;
  logic             restart;
  sfpf_pkg::frame_t upd;

  assign ext_pos = EXT_W'(pos);
  assign pay_end = EXT_W'(PAYLOAD_START) + {1'b0, cur.length};
  assign trl_idx = ext_pos - pay_end;
  assign pay_idx = ext_pos - EXT_W'(PAYLOAD_START);
  assign new_len = {cur.length[15:8], rx_byte};
  assign lo_next = add_mod(cur.sum_low, rx_byte);
  assign hi_next = add_mod(cur.sum_high, lo_next);

  // frame decode by byte position
  always_comb begin
    upd     = cur;
    restart = 1'b0;
    res     = '0;
    res.status = sfpf_pkg::ST_UNFINISHED;
    if (ext_pos < EXT_W'(HEADER_LEN)) begin
      if (rx_byte != header_pattern[8*pos[1:0] +: 8]) begin
        res.status = sfpf_pkg::ST_RESET;
        restart    = 1'b1;
      end
    end else if (ext_pos == EXT_W'(HEADER_LEN)) begin
      upd.command = rx_byte;
    end else if (ext_pos == EXT_W'(HEADER_LEN + 1)) begin
      upd.length = {rx_byte, 8'h00};
    end else if (ext_pos == EXT_W'(HEADER_LEN + 2)) begin
      upd.length = new_len;
      if (new_len > 16'(MAX_PAYLOAD)) begin
        res.status = sfpf_pkg::ST_RESET;
        restart    = 1'b1;
      end
    end else if (ext_pos == EXT_W'(HEADER_LEN + 3)) begin
      upd.checksum = {rx_byte, 8'h00};
    end else if (ext_pos == EXT_W'(HEADER_LEN + 4)) begin
      upd.checksum = {cur.checksum[15:8], rx_byte};
    end else if (ext_pos < pay_end) begin
      // payload byte: running sums and pass-through
      upd.sum_low       = lo_next;
      upd.sum_high      = hi_next;
      res.payload_valid = 1'b1;
      res.payload_byte  = rx_byte;
      res.payload_index = pay_idx[9:0];
    end else begin
      // trailer byte
      if (rx_byte != trailer_pattern[8*trl_idx[1:0] +: 8]) begin
        res.status = sfpf_pkg::ST_RESET;
        restart    = 1'b1;
      end else if (trl_idx >= EXT_W'(TRAILER_LEN - 1)) begin
        res.status    = ({cur.sum_high, cur.sum_low} == cur.checksum) ?
                        sfpf_pkg::ST_VERIFIED : sfpf_pkg::ST_CKERR;
        res.frame_end = 1'b1;
        restart       = 1'b1;
      end
    end
    res.command        = upd.command;
    res.payload_length = upd.length[10:0];
  end

  // state after this byte
  always_comb begin
    if (restart) begin
      frame_next = '0;
      pos_next   = '0;
    end else begin
      frame_next = upd;
      pos_next   = pos + POS_W'(1);
    end
  end

endmodule
